>>> design/ioas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ioas_pkg
// Shared types and constants of the infrared obstacle avoidance sequencer:
// motor command codes, phase codes, register indexes and the register group.
// ----------------------------------------------------------------------------
package ioas_pkg;

   localparam int REG_BITS            = 12;
   localparam int TICK_COUNT_BITS_DEF = 12;
   localparam int CSR_ADDR_BITS       = 2;

   typedef enum logic [2:0] {
      CMD_STOP    = 3'd0,
      CMD_FORWARD = 3'd1,
      CMD_REVERSE = 3'd2,
      CMD_LEFT    = 3'd3,
      CMD_RIGHT   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_REVERSE = 2'd1,
      PH_TURN    = 2'd2
   } phase_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_BACK_ONE_SIDE = 2'd0,
      REG_BACK_BOTH     = 2'd1,
      REG_TURN          = 2'd2
   } reg_index_type;

   localparam logic [1:0] CODE_BOTH  = 2'd3;
   localparam logic [1:0] CODE_RIGHT = 2'd2;
   localparam logic [1:0] CODE_NONE  = 2'd0;

   localparam logic [REG_BITS-1:0] BACK_ONE_SIDE_RESET = 12'd500;
   localparam logic [REG_BITS-1:0] BACK_BOTH_RESET     = 12'd800;
   localparam logic [REG_BITS-1:0] TURN_RESET          = 12'd500;

   typedef struct packed {
      logic [REG_BITS-1:0] back_one_side;
      logic [REG_BITS-1:0] back_both;
      logic [REG_BITS-1:0] turn;
   } cfg_type;

endpackage : ioas_pkg
`default_nettype wire

>>> design/ioas_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ioas_csr
// Timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module ioas_csr
   import ioas_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [REG_BITS-1:0]      csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_BACK_ONE_SIDE: cfg_in.back_one_side = csr_wdata;
            REG_BACK_BOTH:     cfg_in.back_both     = csr_wdata;
            REG_TURN:          cfg_in.turn          = csr_wdata;
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.back_one_side <= BACK_ONE_SIDE_RESET;
         cfg_ff.back_both     <= BACK_BOTH_RESET;
         cfg_ff.turn          <= TURN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : ioas_csr
`default_nettype wire

>>> design/ioas_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ioas_step
// Next-state and command logic for one tick: obstacle confirmation, phase
// sequencing and the phase countdown.
// ----------------------------------------------------------------------------
module ioas_step
   import ioas_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
)(
   input  wire logic                       left_raw,
   input  wire logic                       right_raw,
   input  wire logic                       prev_left,
   input  wire logic                       prev_right,
   input  wire phase_type                  phase,
   input  wire logic [TICK_COUNT_BITS-1:0] ticks,
   input  wire logic                       turn_right,
   input  wire cfg_type                    cfg,
   output phase_type                       phase_next,
   output logic [TICK_COUNT_BITS-1:0]      ticks_next,
   output logic                            turn_right_next,
   output cmd_type                         cmd,
   output logic [1:0]                      code
);

   localparam int CMP_BITS = (TICK_COUNT_BITS > REG_BITS) ? TICK_COUNT_BITS : REG_BITS;
   localparam logic [CMP_BITS-1:0] CNT_MAX = CMP_BITS'((64'd1 << TICK_COUNT_BITS) - 64'd1);

   // Saturate a register value to the largest count the counter holds.
   function automatic logic [TICK_COUNT_BITS-1:0] load_count(input logic [REG_BITS-1:0] v);
      logic [CMP_BITS-1:0] wide;
      wide = CMP_BITS'(v);
      if (wide > CNT_MAX) begin
         wide = CNT_MAX;
      end
      return wide[TICK_COUNT_BITS-1:0];
   endfunction

   logic    last_tick;
   cmd_type turn_cmd;

   assign code      = {right_raw & prev_right, left_raw & prev_left};
   assign last_tick = (ticks <= TICK_COUNT_BITS'(1));
   assign turn_cmd  = turn_right ? CMD_RIGHT : CMD_LEFT;

   always_comb begin
      phase_next      = phase;
      ticks_next      = ticks;
      turn_right_next = turn_right;
      cmd             = CMD_FORWARD;
      unique case (phase)
         PH_REVERSE: begin
            phase_next = PH_TURN;
            ticks_next = load_count(cfg.turn);
            if (code != CODE_NONE) begin
               cmd = CMD_STOP;
            end else if (last_tick) begin
               cmd = turn_cmd;
            end else begin
               phase_next = PH_REVERSE;
               ticks_next = ticks - TICK_COUNT_BITS'(1);
               cmd        = CMD_REVERSE;
            end
         end
         PH_TURN: begin
            phase_next = PH_IDLE;
            ticks_next = '0;
            if (code != CODE_NONE) begin
               cmd = CMD_STOP;
            end else if (last_tick) begin
               cmd = CMD_FORWARD;
            end else begin
               phase_next = PH_TURN;
               ticks_next = ticks - TICK_COUNT_BITS'(1);
               cmd        = turn_cmd;
            end
         end
         default: begin
            // Idle, and the unused phase code that behaves as idle.
            phase_next = PH_IDLE;
            if (code != CODE_NONE) begin
               cmd             = CMD_REVERSE;
               phase_next      = PH_REVERSE;
               ticks_next      = load_count((code == CODE_BOTH) ? cfg.back_both
                                                                : cfg.back_one_side);
               turn_right_next = (code != CODE_RIGHT);
            end
         end
      endcase
   end

endmodule : ioas_step
`default_nettype wire

>>> design/ir_obstacle_avoid_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_obstacle_avoid_sequencer
// Obstacle avoidance sequencer driven by one item per 1 ms sensor tick.
// ----------------------------------------------------------------------------
// Each item on req carries the raw left and right sensor bits of one tick and
// yields exactly one item on rsp with the motor command and the confirmed
// obstacle code. The block takes one item per clock cycle: the sequencing
// state and a single output register are both loaded on acceptance, so the
// result shows on rsp in the next cycle. req_tready stays high while that
// register is empty or being emptied, so the rate is set only by rsp_tready.
// Timing registers should be written only while no item is in flight.
module ir_obstacle_avoid_sequencer
   import ioas_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,  // [0] left_blocked_raw, [1] right_blocked_raw
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,  // [2:0] motor_command, [4:3] obstacle_code
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [REG_BITS-1:0]      csr_wdata
);

   cfg_type cfg;

   phase_type                  phase_ff, phase_in;
   logic [TICK_COUNT_BITS-1:0] ticks_ff, ticks_in;
   logic                       turn_right_ff, turn_right_in;
   logic                       prev_left_ff, prev_right_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_data_ff;
   cmd_type                    cmd;
   logic [1:0]                 code;
   logic                       accept;

   ioas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ioas_step #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_step (
      .left_raw        (req_tdata[0]),
      .right_raw       (req_tdata[1]),
      .prev_left       (prev_left_ff),
      .prev_right      (prev_right_ff),
      .phase           (phase_ff),
      .ticks           (ticks_ff),
      .turn_right      (turn_right_ff),
      .cfg             (cfg),
      .phase_next      (phase_in),
      .ticks_next      (ticks_in),
      .turn_right_next (turn_right_in),
      .cmd             (cmd),
      .code            (code)
   );

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         ticks_ff      <= '0;
         turn_right_ff <= 1'b0;
         prev_left_ff  <= 1'b0;
         prev_right_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            ticks_ff      <= ticks_in;
            turn_right_ff <= turn_right_in;
            prev_left_ff  <= req_tdata[0];
            prev_right_ff <= req_tdata[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {3'b000, code, cmd};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : ir_obstacle_avoid_sequencer
`default_nettype wire

>>> design/ioas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ioas_checker
// Port-level checks of the obstacle avoidance sequencer, bound to the top.
// ----------------------------------------------------------------------------
module ioas_checker
   import ioas_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [7:0]               rsp_tdata
);

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // With the output register empty the block must take an item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output register");

   // An accepted item always shows up as a result on the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // Stop is only issued on a confirmed obstacle; forward never is.
   a_stop_needs_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == CMD_STOP) |-> (rsp_tdata[4:3] != CODE_NONE))
      else $error("stop without confirmed obstacle");

   a_forward_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == CMD_FORWARD) |-> (rsp_tdata[4:3] == CODE_NONE))
      else $error("forward with confirmed obstacle");

endmodule : ioas_checker

bind ir_obstacle_avoid_sequencer ioas_checker u_ioas_checker (.*);
`default_nettype wire

>>> tb/ir_obstacle_avoid_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_obstacle_avoid_sequencer_test
// Self-checking bench for the infrared obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
// A short table of sensor ticks and register settings opens the run. It
// covers confirmation on two ticks, reverse and turn timeouts, stop on a
// confirmed obstacle during either timed phase, and zero timing registers.
// Random phases follow under several register settings. Most of their ticks
// form clear stretches followed by held obstacles, so that the sequencer
// walks through reverse and turn. The rest are single-tick glitches and
// noise. A behavioral model of the sequencer predicts every result that the
// table leaves open. Both stream sides stall at random, except in one phase.
// ----------------------------------------------------------------------------
module ir_obstacle_avoid_sequencer_test;
   import ioas_pkg::*;

   localparam int          STALL_LIMIT = 4000;
   localparam logic [1:0]  CODE_LEFT   = 2'd1;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] code;
   } motor_out;

   typedef enum logic {ROW_TICK, ROW_CFG} row_kind;

   typedef struct packed {
      row_kind  kind;
      cfg_type  cfg;
      logic     left;
      logic     right;
      logic     typed;
      motor_out exp;
   } stim_row;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;   // [0] left_blocked_raw, [1] right_blocked_raw
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [7:0]               rsp_tdata;        // [2:0] motor_command, [4:3] obstacle_code
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [REG_BITS-1:0]      csr_wdata = '0;

   // Sequencer model state, starting from its reset values.
   cfg_type             regs = '{back_one_side: BACK_ONE_SIDE_RESET,
                                 back_both: BACK_BOTH_RESET, turn: TURN_RESET};
   phase_type           seq_phase = PH_IDLE;
   logic [REG_BITS-1:0] ticks_left = '0;
   logic                turn_right = 1'b0;
   logic                prev_left = 1'b0;
   logic                prev_right = 1'b0;

   motor_out pending_cmds[$];
   stim_row  directed[$];
   int       mismatches = 0;
   int       stall_cycles = 0;
   bit       steady = 1'b0;

   ir_obstacle_avoid_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic motor_out step_sequencer(input logic l, input logic r);
      motor_out   res;
      logic [1:0] code;
      code = {r & prev_right, l & prev_left};
      prev_left  = l;
      prev_right = r;
      res.code   = code;
      case (seq_phase)
         PH_REVERSE: begin
            if (code != CODE_NONE) begin
               res.cmd    = CMD_STOP;
               seq_phase  = PH_TURN;
               ticks_left = regs.turn;
            end else if (ticks_left <= 1) begin
               // A count of zero ends the phase on the next tick, like a count of one.
               res.cmd    = turn_right ? CMD_RIGHT : CMD_LEFT;
               seq_phase  = PH_TURN;
               ticks_left = regs.turn;
            end else begin
               ticks_left = ticks_left - 1'b1;
               res.cmd    = CMD_REVERSE;
            end
         end
         PH_TURN: begin
            if (code != CODE_NONE) begin
               res.cmd    = CMD_STOP;
               seq_phase  = PH_IDLE;
               ticks_left = '0;
            end else if (ticks_left <= 1) begin
               res.cmd    = CMD_FORWARD;
               seq_phase  = PH_IDLE;
               ticks_left = '0;
            end else begin
               ticks_left = ticks_left - 1'b1;
               res.cmd    = turn_right ? CMD_RIGHT : CMD_LEFT;
            end
         end
         default: begin
            seq_phase = PH_IDLE;
            if (code == CODE_NONE) begin
               res.cmd = CMD_FORWARD;
            end else begin
               res.cmd    = CMD_REVERSE;
               seq_phase  = PH_REVERSE;
               ticks_left = (code == CODE_BOTH) ? regs.back_both : regs.back_one_side;
               turn_right = (code != CODE_RIGHT);
            end
         end
      endcase
      return res;
   endfunction

   function automatic stim_row tick_row(input logic l, input logic r);
      stim_row row;
      row       = '0;
      row.kind  = ROW_TICK;
      row.left  = l;
      row.right = r;
      return row;
   endfunction

   function automatic stim_row checked_row(input logic l, input logic r,
                                           input cmd_type cmd, input logic [1:0] code);
      stim_row row;
      row          = tick_row(l, r);
      row.typed    = 1'b1;
      row.exp.cmd  = cmd;
      row.exp.code = code;
      return row;
   endfunction

   function automatic stim_row cfg_row(input cfg_type c);
      stim_row row;
      row      = '0;
      row.kind = ROW_CFG;
      row.cfg  = c;
      return row;
   endfunction

   // Offer one tick, wait for its acceptance and queue the result it must give.
   task automatic send_tick(input logic l, input logic r, input logic typed,
                            input motor_out typed_exp);
      motor_out predicted;
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r, l};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = step_sequencer(l, r);
      pending_cmds.push_back(typed ? typed_exp : predicted);
   endtask

   // Every tick yields one result, so an empty queue means idle.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(input cfg_type c);
      csr_we    <= 1'b1;
      csr_addr  <= REG_BACK_ONE_SIDE;
      csr_wdata <= c.back_one_side;
      @(posedge clock);
      csr_addr  <= REG_BACK_BOTH;
      csr_wdata <= c.back_both;
      @(posedge clock);
      csr_addr  <= REG_TURN;
      csr_wdata <= c.turn;
      @(posedge clock);
      csr_we    <= 1'b0;
      regs = c;
   endtask

   task automatic run_phase(input cfg_type c, input int count, input bit no_gaps);
      int sent;
      int span;
      int sel;
      int hold;
      logic [1:0] sides;
      drain();
      write_config(c);
      steady = no_gaps;
      span = int'(c.back_both) + int'(c.turn) + 2;
      if (span > 40) span = 40;
      sent = 0;
      while (sent < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            sent++;
         end else if (sel < 22) begin
            // A glitch on one tick only must never be confirmed.
            sides = 2'($urandom_range(1, 3));
            send_tick(sides[0], sides[1], 1'b0, '0);
            send_tick(1'b0, 1'b0, 1'b0, '0);
            sent += 2;
         end else begin
            repeat ($urandom_range(1, span)) begin
               send_tick(1'b0, 1'b0, 1'b0, '0);
               sent++;
            end
            sides = 2'($urandom_range(1, 3));
            hold  = $urandom_range(2, 3);
            repeat (hold) begin
               send_tick(sides[0], sides[1], 1'b0, '0);
               sent++;
            end
         end
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      motor_out exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            $error("result with no expectation waiting: motor_command %0d, obstacle_code %0d",
                   rsp_tdata[2:0], rsp_tdata[4:3]);
            mismatches++;
         end else begin
            exp = pending_cmds.pop_front();
            if (rsp_tdata[2:0] !== exp.cmd) begin
               $error("motor_command: expected %0d, got %0d", exp.cmd, rsp_tdata[2:0]);
               mismatches++;
            end
            if (rsp_tdata[4:3] !== exp.code) begin
               $error("obstacle_code: expected %0d, got %0d", exp.code, rsp_tdata[4:3]);
               mismatches++;
            end
         end
      end
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row row;

      // Reset timing: confirmation, stop during reverse and during turn.
      directed.push_back(checked_row(1'b0, 1'b0, CMD_FORWARD, CODE_NONE));
      directed.push_back(checked_row(1'b1, 1'b1, CMD_FORWARD, CODE_NONE));
      directed.push_back(checked_row(1'b1, 1'b1, CMD_REVERSE, CODE_BOTH));
      directed.push_back(tick_row(1'b0, 1'b0));
      directed.push_back(tick_row(1'b1, 1'b0));
      directed.push_back(checked_row(1'b1, 1'b0, CMD_STOP, CODE_LEFT));
      directed.push_back(tick_row(1'b0, 1'b0));
      directed.push_back(tick_row(1'b0, 1'b1));
      directed.push_back(checked_row(1'b0, 1'b1, CMD_STOP, CODE_RIGHT));
      // Shortest reverse, longest reverse for both sides, short turn.
      directed.push_back(cfg_row('{back_one_side: 12'd1, back_both: 12'd4095, turn: 12'd2}));
      directed.push_back(checked_row(1'b0, 1'b0, CMD_FORWARD, CODE_NONE));
      directed.push_back(tick_row(1'b1, 1'b0));
      directed.push_back(checked_row(1'b1, 1'b0, CMD_REVERSE, CODE_LEFT));
      directed.push_back(tick_row(1'b0, 1'b0));
      directed.push_back(tick_row(1'b0, 1'b0));
      directed.push_back(tick_row(1'b0, 1'b0));
      // Zero timing registers behave as a single tick.
      directed.push_back(cfg_row('{back_one_side: 12'd0, back_both: 12'd4095, turn: 12'd0}));
      directed.push_back(tick_row(1'b0, 1'b1));
      directed.push_back(checked_row(1'b0, 1'b1, CMD_REVERSE, CODE_RIGHT));
      directed.push_back(tick_row(1'b0, 1'b0));
      directed.push_back(tick_row(1'b0, 1'b0));
      directed.push_back(tick_row(1'b1, 1'b1));
      directed.push_back(checked_row(1'b1, 1'b1, CMD_REVERSE, CODE_BOTH));
      directed.push_back(checked_row(1'b1, 1'b1, CMD_STOP, CODE_BOTH));
      directed.push_back(checked_row(1'b1, 1'b1, CMD_STOP, CODE_BOTH));
      directed.push_back(tick_row(1'b0, 1'b0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         if (row.kind == ROW_CFG) begin
            drain();
            write_config(row.cfg);
         end else begin
            send_tick(row.left, row.right, row.typed, row.exp);
         end
      end

      run_phase('{back_one_side: 12'd3, back_both: 12'd5, turn: 12'd4}, 160, 1'b0);
      run_phase('{back_one_side: 12'd1, back_both: 12'd1, turn: 12'd1}, 120, 1'b1);
      run_phase('{back_one_side: 12'd4095, back_both: 12'd4095, turn: 12'd4095}, 60, 1'b0);
      run_phase('{back_one_side: 12'd12, back_both: 12'd30, turn: 12'd8}, 160, 1'b0);
      run_phase('{back_one_side: 12'd2, back_both: 12'd7, turn: 12'd1}, 120, 1'b0);
      run_phase('{back_one_side: BACK_ONE_SIDE_RESET, back_both: BACK_BOTH_RESET,
                  turn: TURN_RESET}, 60, 1'b0);

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
